FILE: rtl/core/hrhp_pkg.sv
`default_nettype none

package hrhp_pkg;

  // Default field limits.
  localparam int METHOD_MAX_DEF = 15;
  localparam int TEXT_MAX_DEF   = 255;
  localparam int BODY_MAX_DEF   = 4095;

  // Character codes used by the parser.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Lengths of the words that header names and values are matched against.
  localparam int CONN_LEN  = 10;
  localparam int CLEN_LEN  = 14;
  localparam int CLOSE_LEN = 5;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef enum logic [2:0] {
    PH_METHOD     = 3'd0,
    PH_PATH       = 3'd1,
    PH_LINE_REST  = 3'd2,
    PH_NAME       = 3'd3,
    PH_VALUE      = 3'd4,
    PH_VALUE_TAIL = 3'd5,
    PH_BODY       = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_METHOD  = 3'd0,
    K_PATH    = 3'd1,
    K_NAME    = 3'd2,
    K_VALUE   = 3'd3,
    K_BODY    = 3'd4,
    K_DISCARD = 3'd5
  } kind_t;

  // Number parser stages: leading white space, digits, done.
  typedef enum logic [1:0] {
    NS_LEAD   = 2'd0,
    NS_DIGITS = 2'd1,
    NS_DONE   = 2'd2
  } num_stage_t;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         data_out;
    kind_t              kind;
    logic               summary_valid;
    logic               headers_complete;
    logic               keep_alive;
    logic signed [31:0] length_value;
  } out_item_t;

  function automatic logic [7:0] conn_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "n";
      4'd4:    c = "e";
      4'd5:    c = "c";
      4'd6:    c = "t";
      4'd7:    c = "i";
      4'd8:    c = "o";
      4'd9:    c = "n";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] clen_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] close_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "c";
      3'd1:    c = "l";
      3'd2:    c = "o";
      3'd3:    c = "s";
      3'd4:    c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/http_request_header_parser_top.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    hrhp_pkg::in_item_t  (byte, last flag)
// out_     output     out_valid / out_stall  hrhp_pkg::out_item_t (byte, kind, summary)
//
// Each transaction passes through the input register and then, with the parser
// state update, into the result register, which offers it on the output. A new
// byte can be accepted every cycle while the output is not stalled.
// Reset is synchronous and active low; it empties both registers and returns
// the parser to the start of a request. A stall on the output holds the result
// register and, once the input register is also full, stalls the input.
module http_request_header_parser_top #(
  parameter int METHOD_MAX = hrhp_pkg::METHOD_MAX_DEF,
  parameter int TEXT_MAX   = hrhp_pkg::TEXT_MAX_DEF,
  parameter int BODY_MAX   = hrhp_pkg::BODY_MAX_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hrhp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hrhp_pkg::out_item_t      out_data
);

  logic                s1_valid;
  hrhp_pkg::in_item_t  s1_item;
  hrhp_pkg::out_item_t result;
  logic                adv;
  logic                fire;

  // The parser state moves only when a byte leaves the input register for the
  // result register, so every transaction updates the state exactly once.
  assign fire = s1_valid & adv;

  hrhp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  hrhp_parse #(
    .METHOD_MAX (METHOD_MAX),
    .TEXT_MAX   (TEXT_MAX),
    .BODY_MAX   (BODY_MAX)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item),
    .result (result)
  );

  hrhp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .result    (result),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/core/hrhp_in_stage.sv
`default_nettype none

module hrhp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire hrhp_pkg::in_item_t in_data,
  input  wire logic              adv,
  output logic                   s1_valid,
  output hrhp_pkg::in_item_t     s1_item
);

  logic               valid_r, valid_nxt;
  hrhp_pkg::in_item_t item_r;
  logic               load;

  // The register can take a new byte whenever it is empty or moving on.
  assign in_stall  = valid_r & ~adv;
  assign load      = in_valid & ~in_stall;
  assign valid_nxt = load | (valid_r & ~adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

`default_nettype wire

FILE: rtl/core/hrhp_parse.sv
`default_nettype none

module hrhp_parse #(
  parameter int METHOD_MAX = hrhp_pkg::METHOD_MAX_DEF,
  parameter int TEXT_MAX   = hrhp_pkg::TEXT_MAX_DEF,
  parameter int BODY_MAX   = hrhp_pkg::BODY_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire hrhp_pkg::in_item_t item,
  output hrhp_pkg::out_item_t     result
);

  localparam int BIG_MAX = (METHOD_MAX > TEXT_MAX) ?
                           ((METHOD_MAX > BODY_MAX) ? METHOD_MAX : BODY_MAX) :
                           ((TEXT_MAX > BODY_MAX) ? TEXT_MAX : BODY_MAX);
  localparam int FC_W = $clog2(BIG_MAX + 1);
  localparam logic [FC_W-1:0] METHOD_LIM = FC_W'(METHOD_MAX);
  localparam logic [FC_W-1:0] TEXT_LIM   = FC_W'(TEXT_MAX);
  localparam logic [FC_W-1:0] BODY_LIM   = FC_W'(BODY_MAX);
  localparam logic [FC_W-1:0] CONN_CNT   = FC_W'(hrhp_pkg::CONN_LEN);
  localparam logic [FC_W-1:0] CLEN_CNT   = FC_W'(hrhp_pkg::CLEN_LEN);
  localparam logic [FC_W-1:0] CLOSE_CNT  = FC_W'(hrhp_pkg::CLOSE_LEN);
  localparam logic [FC_W-1:0] FC_ONE     = FC_W'(1);

  hrhp_pkg::phase_t     phase_r,  phase_nxt;
  logic [FC_W-1:0]      fc_r,     fc_nxt;
  logic                 mconn_r,  mconn_nxt;
  logic                 mlen_r,   mlen_nxt;
  logic                 mclose_r, mclose_nxt;
  logic [31:0]          len_r,    len_nxt;
  logic                 lneg_r,   lneg_nxt;
  logic                 ka_r,     ka_nxt;
  logic [1:0]           track_r,  track_nxt;
  logic                 term_r,   term_nxt;
  hrhp_pkg::num_stage_t nst_r,    nst_nxt;
  logic [31:0]          nmag_r,   nmag_nxt;
  logic                 nneg_r,   nneg_nxt;

  logic [7:0]           b;
  hrhp_pkg::kind_t      kind;
  logic                 white;
  logic                 digit;
  logic [35:0]          prod;
  logic [31:0]          lim;
  logic [2:0]           trk;
  logic [7:0]           term_char;
  logic [31:0]          cl;

  assign b     = item.data_in;
  assign white = (b == hrhp_pkg::CH_SP) || (b >= hrhp_pkg::CH_TAB && b <= hrhp_pkg::CH_CR);
  assign digit = (b >= hrhp_pkg::CH_ZERO) && (b <= hrhp_pkg::CH_NINE);

  always_comb begin
    phase_nxt  = phase_r;
    fc_nxt     = fc_r;
    mconn_nxt  = mconn_r;
    mlen_nxt   = mlen_r;
    mclose_nxt = mclose_r;
    len_nxt    = len_r;
    lneg_nxt   = lneg_r;
    ka_nxt     = ka_r;
    track_nxt  = track_r;
    term_nxt   = term_r;
    nst_nxt    = nst_r;
    nmag_nxt   = nmag_r;
    nneg_nxt   = nneg_r;
    kind       = hrhp_pkg::K_DISCARD;
    prod       = '0;
    lim        = hrhp_pkg::POS_LIMIT;
    trk        = '0;
    term_char  = hrhp_pkg::CH_CR;
    cl         = '0;

    case (phase_r)
      hrhp_pkg::PH_METHOD: begin
        if (b == hrhp_pkg::CH_SP) begin
          phase_nxt = hrhp_pkg::PH_PATH;
          fc_nxt    = '0;
        end else if (fc_r < METHOD_LIM) begin
          kind   = hrhp_pkg::K_METHOD;
          fc_nxt = fc_r + FC_ONE;
        end
      end
      hrhp_pkg::PH_PATH: begin
        if (b == hrhp_pkg::CH_SP) begin
          if (fc_r != '0) begin
            phase_nxt = hrhp_pkg::PH_LINE_REST;
          end
        end else if (fc_r < TEXT_LIM) begin
          kind   = hrhp_pkg::K_PATH;
          fc_nxt = fc_r + FC_ONE;
        end
      end
      hrhp_pkg::PH_LINE_REST: begin
        if (b == hrhp_pkg::CH_LF) begin
          phase_nxt  = hrhp_pkg::PH_NAME;
          fc_nxt     = '0;
          mconn_nxt  = 1'b1;
          mlen_nxt   = 1'b1;
          mclose_nxt = 1'b1;
          nst_nxt    = hrhp_pkg::NS_LEAD;
          nmag_nxt   = '0;
          nneg_nxt   = 1'b0;
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (b == hrhp_pkg::CH_COLON) begin
          mconn_nxt = mconn_r && (fc_r == CONN_CNT);
          mlen_nxt  = mlen_r && (fc_r == CLEN_CNT);
          fc_nxt    = '0;
          phase_nxt = hrhp_pkg::PH_VALUE;
        end else if (b == hrhp_pkg::CH_LF) begin
          // A line without a colon is dropped.
          fc_nxt     = '0;
          mconn_nxt  = 1'b1;
          mlen_nxt   = 1'b1;
          mclose_nxt = 1'b1;
          nst_nxt    = hrhp_pkg::NS_LEAD;
          nmag_nxt   = '0;
          nneg_nxt   = 1'b0;
        end else if (b == hrhp_pkg::CH_CR) begin
          mconn_nxt = 1'b0;
          mlen_nxt  = 1'b0;
        end else if (b == hrhp_pkg::CH_SP && fc_r == '0) begin
          // Leading space of the name is skipped.
        end else if (fc_r < TEXT_LIM) begin
          kind      = hrhp_pkg::K_NAME;
          mconn_nxt = mconn_r && (fc_r < CONN_CNT) &&
                      (b == hrhp_pkg::conn_char(fc_r[3:0]));
          mlen_nxt  = mlen_r && (fc_r < CLEN_CNT) &&
                      (b == hrhp_pkg::clen_char(fc_r[3:0]));
          fc_nxt    = fc_r + FC_ONE;
        end else begin
          mconn_nxt = 1'b0;
          mlen_nxt  = 1'b0;
        end
      end
      hrhp_pkg::PH_VALUE: begin
        if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF) begin
          mclose_nxt = mclose_r && (fc_r == CLOSE_CNT);
          if (b == hrhp_pkg::CH_LF) begin
            phase_nxt = hrhp_pkg::PH_NAME;
            if (mconn_r) begin
              ka_nxt = ~mclose_nxt;
            end
            if (mlen_r) begin
              len_nxt  = nmag_r;
              lneg_nxt = nneg_r && (nmag_r != '0);
            end
            fc_nxt     = '0;
            mconn_nxt  = 1'b1;
            mlen_nxt   = 1'b1;
            mclose_nxt = 1'b1;
            nst_nxt    = hrhp_pkg::NS_LEAD;
            nmag_nxt   = '0;
            nneg_nxt   = 1'b0;
          end else begin
            phase_nxt = hrhp_pkg::PH_VALUE_TAIL;
          end
        end else if (b == hrhp_pkg::CH_SP && fc_r == '0) begin
          // Leading space of the value is skipped.
        end else if (fc_r < TEXT_LIM) begin
          kind       = hrhp_pkg::K_VALUE;
          mclose_nxt = mclose_r && (fc_r < CLOSE_CNT) &&
                       (b == hrhp_pkg::close_char(fc_r[2:0]));
          fc_nxt     = fc_r + FC_ONE;
          // Number parser: white space, an optional sign, then digits.
          if (nst_r == hrhp_pkg::NS_LEAD) begin
            if (white) begin
              nst_nxt = hrhp_pkg::NS_LEAD;
            end else if (b == hrhp_pkg::CH_PLUS || b == hrhp_pkg::CH_MINUS) begin
              nneg_nxt = (b == hrhp_pkg::CH_MINUS);
              nst_nxt  = hrhp_pkg::NS_DIGITS;
            end else begin
              nst_nxt = hrhp_pkg::NS_DIGITS;
            end
          end
          if ((nst_r == hrhp_pkg::NS_DIGITS) ||
              (nst_r == hrhp_pkg::NS_LEAD && !white &&
               b != hrhp_pkg::CH_PLUS && b != hrhp_pkg::CH_MINUS)) begin
            if (digit) begin
              lim  = nneg_r ? hrhp_pkg::NEG_LIMIT : hrhp_pkg::POS_LIMIT;
              prod = {1'b0, nmag_r, 3'b000} + {3'b000, nmag_r, 1'b0} +
                     {32'd0, b[3:0]};
              nmag_nxt = (prod > {4'd0, lim}) ? lim : prod[31:0];
            end else begin
              nst_nxt = hrhp_pkg::NS_DONE;
            end
          end
        end
      end
      hrhp_pkg::PH_VALUE_TAIL: begin
        if (b == hrhp_pkg::CH_LF) begin
          phase_nxt = hrhp_pkg::PH_NAME;
          if (mconn_r) begin
            ka_nxt = ~mclose_r;
          end
          if (mlen_r) begin
            len_nxt  = nmag_r;
            lneg_nxt = nneg_r && (nmag_r != '0);
          end
          fc_nxt     = '0;
          mconn_nxt  = 1'b1;
          mlen_nxt   = 1'b1;
          mclose_nxt = 1'b1;
          nst_nxt    = hrhp_pkg::NS_LEAD;
          nmag_nxt   = '0;
          nneg_nxt   = 1'b0;
        end
      end
      hrhp_pkg::PH_BODY: begin
        if (len_r != '0 && !lneg_r && fc_r < BODY_LIM) begin
          kind   = hrhp_pkg::K_BODY;
          fc_nxt = fc_r + FC_ONE;
        end
      end
      default: begin
      end
    endcase

    // Blank line search: CR LF CR LF, wherever it falls before the body.
    if (phase_nxt != hrhp_pkg::PH_BODY) begin
      term_char = track_r[0] ? hrhp_pkg::CH_LF : hrhp_pkg::CH_CR;
      if (b == term_char) begin
        trk = {1'b0, track_r} + 3'd1;
      end else begin
        trk = (b == hrhp_pkg::CH_CR) ? 3'd1 : 3'd0;
      end
      if (trk[2]) begin
        term_nxt  = 1'b1;
        phase_nxt = hrhp_pkg::PH_BODY;
        fc_nxt    = '0;
        track_nxt = '0;
      end else begin
        track_nxt = trk[1:0];
      end
    end

    cl = lneg_nxt ? (32'd0 - len_nxt) : len_nxt;

    result.data_out         = b;
    result.kind             = kind;
    result.summary_valid    = item.last_in;
    result.headers_complete = item.last_in & term_nxt;
    result.keep_alive       = item.last_in & ka_nxt;
    result.length_value     = item.last_in ? cl : 32'd0;

    // The last byte closes the request and the parser starts afresh.
    if (item.last_in) begin
      phase_nxt  = hrhp_pkg::PH_METHOD;
      fc_nxt     = '0;
      mconn_nxt  = 1'b1;
      mlen_nxt   = 1'b1;
      mclose_nxt = 1'b1;
      len_nxt    = '0;
      lneg_nxt   = 1'b0;
      ka_nxt     = 1'b1;
      track_nxt  = '0;
      term_nxt   = 1'b0;
      nst_nxt    = hrhp_pkg::NS_LEAD;
      nmag_nxt   = '0;
      nneg_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hrhp_pkg::PH_METHOD;
      fc_r     <= '0;
      mconn_r  <= 1'b1;
      mlen_r   <= 1'b1;
      mclose_r <= 1'b1;
      len_r    <= '0;
      lneg_r   <= 1'b0;
      ka_r     <= 1'b1;
      track_r  <= '0;
      term_r   <= 1'b0;
      nst_r    <= hrhp_pkg::NS_LEAD;
      nmag_r   <= '0;
      nneg_r   <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      fc_r     <= fc_nxt;
      mconn_r  <= mconn_nxt;
      mlen_r   <= mlen_nxt;
      mclose_r <= mclose_nxt;
      len_r    <= len_nxt;
      lneg_r   <= lneg_nxt;
      ka_r     <= ka_nxt;
      track_r  <= track_nxt;
      term_r   <= term_nxt;
      nst_r    <= nst_nxt;
      nmag_r   <= nmag_nxt;
      nneg_r   <= nneg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hrhp_out_stage.sv
`default_nettype none

module hrhp_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                s1_valid,
  input  wire hrhp_pkg::out_item_t result,
  output logic                     adv,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hrhp_pkg::out_item_t      out_data
);

  logic                valid_r, valid_nxt;
  hrhp_pkg::out_item_t data_r;
  logic                load;

  assign adv       = ~valid_r | ~out_stall;
  assign load      = s1_valid & adv;
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: verif/hrhp_check_pkg.sv
`timescale 1ns / 1ps

package hrhp_check_pkg;

  import hrhp_pkg::*;

  // Words that header names and values are compared against, right-aligned.
  localparam logic [111:0] CONN_TEXT  = "Connection";
  localparam logic [111:0] CLEN_TEXT  = "Content-Length";
  localparam logic [111:0] CLOSE_TEXT = "close";

  // Tracks the parser state for every accepted byte, works out the tagged byte
  // that must come out for it, and compares the results in order.
  class request_tag_scoreboard;
    phase_t      phase;
    logic [11:0] field_count;
    logic        name_is_conn;
    logic        name_is_len;
    logic        value_is_close;
    logic [31:0] length_mag;
    logic        length_neg;
    logic        keep_alive;
    logic [1:0]  crlf_seen;
    logic        headers_done;
    num_stage_t  digit_stage;
    logic [31:0] digit_mag;
    logic        digit_neg;
    out_item_t   expected_tags[$];
    int          failures;

    function new();
      failures = 0;
      start_request();
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction

    function void start_line();
      field_count    = '0;
      name_is_conn   = 1'b1;
      name_is_len    = 1'b1;
      value_is_close = 1'b1;
      digit_stage    = NS_LEAD;
      digit_mag      = '0;
      digit_neg      = 1'b0;
    endfunction

    function void start_request();
      phase        = PH_METHOD;
      start_line();
      length_mag   = '0;
      length_neg   = 1'b0;
      keep_alive   = 1'b1;
      crlf_seen    = '0;
      headers_done = 1'b0;
    endfunction

    // A header only takes effect once the LF ending its line arrives.
    function void commit_line();
      if (name_is_conn) keep_alive = !value_is_close;
      if (name_is_len) begin
        length_mag = digit_mag;
        length_neg = digit_neg && digit_mag != 0;
      end
      start_line();
    endfunction

    function logic char_matches(logic [111:0] word, int len, logic [7:0] b);
      if (int'(field_count) >= len) return 1'b0;
      return b == word[8 * (len - 1 - int'(field_count)) +: 8];
    endfunction

    // Reads the value like atoi: white space, an optional sign, then digits
    // that saturate at the signed 32-bit limits.
    function void take_digit(logic [7:0] b);
      logic [63:0] acc;
      logic [31:0] lim;
      if (digit_stage == NS_LEAD) begin
        if (b == CH_SP || (b >= CH_TAB && b <= CH_CR)) return;
        if (b == CH_PLUS || b == CH_MINUS) begin
          digit_neg   = (b == CH_MINUS);
          digit_stage = NS_DIGITS;
          return;
        end
        digit_stage = NS_DIGITS;
      end
      if (digit_stage == NS_DIGITS) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          lim       = digit_neg ? NEG_LIMIT : POS_LIMIT;
          acc       = 64'(digit_mag) * 64'd10 + 64'(b - CH_ZERO);
          digit_mag = (acc > 64'(lim)) ? lim : acc[31:0];
        end else begin
          digit_stage = NS_DONE;
        end
      end
    endfunction

    function void note_byte(in_item_t item);
      logic [7:0] b;
      kind_t      tag;
      out_item_t  want;
      int         track;
      b   = item.data_in;
      tag = K_DISCARD;
      case (phase)
        PH_METHOD: begin
          if (b == CH_SP) begin
            phase       = PH_PATH;
            field_count = '0;
          end else if (field_count < METHOD_MAX_DEF) begin
            tag = K_METHOD;
            field_count++;
          end
        end
        PH_PATH: begin
          if (b == CH_SP) begin
            if (field_count != 0) phase = PH_LINE_REST;
          end else if (field_count < TEXT_MAX_DEF) begin
            tag = K_PATH;
            field_count++;
          end
        end
        PH_LINE_REST: begin
          if (b == CH_LF) begin
            phase = PH_NAME;
            start_line();
          end
        end
        PH_NAME: begin
          if (b == CH_COLON) begin
            name_is_conn = name_is_conn && field_count == CONN_LEN;
            name_is_len  = name_is_len && field_count == CLEN_LEN;
            field_count  = '0;
            phase        = PH_VALUE;
          end else if (b == CH_LF) begin
            start_line();
          end else if (b == CH_CR) begin
            name_is_conn = 1'b0;
            name_is_len  = 1'b0;
          end else if (b == CH_SP && field_count == 0) begin
          end else if (field_count < TEXT_MAX_DEF) begin
            tag          = K_NAME;
            name_is_conn = name_is_conn && char_matches(CONN_TEXT, CONN_LEN, b);
            name_is_len  = name_is_len && char_matches(CLEN_TEXT, CLEN_LEN, b);
            field_count++;
          end else begin
            name_is_conn = 1'b0;
            name_is_len  = 1'b0;
          end
        end
        PH_VALUE: begin
          if (b == CH_CR || b == CH_LF) begin
            value_is_close = value_is_close && field_count == CLOSE_LEN;
            if (b == CH_LF) begin
              commit_line();
              phase = PH_NAME;
            end else begin
              phase = PH_VALUE_TAIL;
            end
          end else if (b == CH_SP && field_count == 0) begin
          end else if (field_count < TEXT_MAX_DEF) begin
            tag            = K_VALUE;
            value_is_close = value_is_close && char_matches(CLOSE_TEXT, CLOSE_LEN, b);
            take_digit(b);
            field_count++;
          end
        end
        PH_VALUE_TAIL: begin
          if (b == CH_LF) begin
            commit_line();
            phase = PH_NAME;
          end
        end
        PH_BODY: begin
          if (length_mag != 0 && !length_neg && field_count < BODY_MAX_DEF) begin
            tag = K_BODY;
            field_count++;
          end
        end
        default: ;
      endcase

      // CR LF CR LF ends the headers from any phase short of the body.
      if (phase != PH_BODY) begin
        track = int'(crlf_seen);
        if (b == (track[0] ? CH_LF : CH_CR)) track++;
        else track = (b == CH_CR) ? 1 : 0;
        if (track == 4) begin
          headers_done = 1'b1;
          phase        = PH_BODY;
          field_count  = '0;
          crlf_seen    = '0;
        end else begin
          crlf_seen = track[1:0];
        end
      end

      want.data_out         = b;
      want.kind             = tag;
      want.summary_valid    = item.last_in;
      want.headers_complete = 1'b0;
      want.keep_alive       = 1'b0;
      want.length_value     = '0;
      if (item.last_in) begin
        want.headers_complete = headers_done;
        want.keep_alive       = keep_alive;
        want.length_value     = length_neg ? -length_mag : length_mag;
        start_request();
      end
      expected_tags.push_back(want);
    endfunction

    function void report_field(string field, longint want, longint got);
      if (want != got) begin
        failures++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_tags.size() == 0) begin
        failures++;
        $display("%0t: result with nothing expected, byte %h kind %0d",
                 $time, got.data_out, got.kind);
        return;
      end
      want = expected_tags.pop_front();
      report_field("data_out", want.data_out, got.data_out);
      report_field("kind", want.kind, got.kind);
      report_field("summary_valid", want.summary_valid, got.summary_valid);
      report_field("headers_complete", want.headers_complete, got.headers_complete);
      report_field("keep_alive", want.keep_alive, got.keep_alive);
      report_field("length_value", want.length_value, got.length_value);
    endfunction
  endclass

endpackage

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import hrhp_pkg::*;
  import hrhp_check_pkg::*;

  // Bytes of random requests to send after the directed part.
  localparam int RANDOM_BYTES = 250;
  // Length of the single long hold-off on the result side, in cycles.
  localparam int HOLD_CYCLES = 300;
  // Watchdog limit.
  localparam int CYCLE_LIMIT = 500_000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  request_tag_scoreboard sb;
  logic [7:0]            msg[$];
  bit                    hold_request;
  int                    cycles;

  string method_names[4] = '{"GET", "POST", "HEAD", "DELETE"};
  string conn_values[6]  = '{"close", "keep-alive", "Close", "clos", "closed", ""};
  // Names that nearly match, plus one with a leading space that does match.
  string odd_names[5]    = '{"connection", "Content-Lengt", "Content-Lengths", "Host",
                             " Content-Length"};

  http_request_header_parser_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog. A run that hangs is reported as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge, before any of the
  // nonblocking updates of that edge land, so the order of events within the
  // time step does not matter. The input transaction is noted before the
  // result is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Sender idle gaps: mostly none, some short and a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  // Receiver: runs of free cycles, sometimes long enough to give stretches
  // with no stalling at all, broken up by stalls that are mostly short.
  function automatic int pick_run();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(20, 100);
  endfunction

  function automatic int pick_stall();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // The result side. When the stimulus asks for it, the receiver holds off
  // for a long stretch so that both pipeline registers fill up and the input
  // is stalled while the sender keeps offering transactions.
  initial begin
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_stall <= 1'b0;
      repeat (pick_run()) @(posedge clk);
      out_stall <= 1'b1;
      repeat (pick_stall()) @(posedge clk);
    end
  end

  // Offers one byte and waits for the edge at which it is taken. Valid stays
  // high into the next byte when no gap follows, so it is never lowered and
  // raised within one time step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends the bytes gathered in msg as one request, last flag on the final one.
  task automatic send_message();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // The sender pauses until every result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_text(string t);
    for (int i = 0; i < t.len(); i++) msg.push_back(t.getc(i));
  endfunction

  function automatic void add_random(int n, logic [7:0] lo, logic [7:0] hi);
    repeat (n) msg.push_back(8'($urandom_range(hi, lo)));
  endfunction

  // Line ends are mostly CR LF, with the odd bare LF.
  function automatic void add_eol();
    if ($urandom_range(0, 5) == 0) add_text("\n");
    else add_text("\r\n");
  endfunction

  // Content-Length values: small numbers mostly, with signs, white space,
  // trailing junk, values around the saturation limits and plain overflow.
  function automatic string length_text();
    string sign_part;
    string digits;
    string tail;
    case ($urandom_range(0, 9))
      0:       sign_part = "-";
      1:       sign_part = "+";
      2:       sign_part = " ";
      3:       sign_part = "\t";
      default: sign_part = "";
    endcase
    case ($urandom_range(0, 9))
      0:       digits = $sformatf("%0d", $urandom_range(999999, 2147483000));
      1:       digits = {"2147483", $sformatf("%0d", $urandom_range(640, 659))};
      2:       digits = {$sformatf("%0d", $urandom), $sformatf("%0d", $urandom_range(0, 99))};
      3:       digits = "";
      default: digits = $sformatf("%0d", $urandom_range(0, 40));
    endcase
    tail = ($urandom_range(0, 7) == 0) ? "x9" : "";
    return {sign_part, digits, tail};
  endfunction

  function automatic void add_header();
    case ($urandom_range(0, 7))
      0, 1: begin
        add_text("Connection:");
        repeat ($urandom_range(0, 2)) msg.push_back(CH_SP);
        add_text(conn_values[$urandom_range(0, 5)]);
      end
      2, 3: begin
        add_text("Content-Length:");
        repeat ($urandom_range(0, 2)) msg.push_back(CH_SP);
        add_text(length_text());
      end
      4: begin
        add_random($urandom_range(1, 12), "a", "z");
        add_text(": ");
        add_random($urandom_range(0, 16), 8'h20, 8'h7E);
      end
      // A line with no colon at all, to be ignored.
      5: add_random($urandom_range(1, 12), "a", "z");
      // A CR inside the name spoils the match.
      6: add_text("Conn\rection: close");
      default: begin
        add_text(odd_names[$urandom_range(0, 4)]);
        add_text(":");
        if ($urandom_range(0, 1) == 0) add_text(conn_values[$urandom_range(0, 5)]);
        else add_text(length_text());
      end
    endcase
    add_eol();
  endfunction

  // A mostly well-formed request with random content. Now and then the method
  // or the path runs past its limit, and one request in ten has no blank line.
  function automatic void build_request();
    msg.delete();
    if ($urandom_range(0, 24) == 0) add_random($urandom_range(16, 20), "A", "Z");
    else add_text(method_names[$urandom_range(0, 3)]);
    add_text(($urandom_range(0, 4) == 0) ? "  /" : " /");
    if ($urandom_range(0, 24) == 0) add_random($urandom_range(250, 262), 8'h21, 8'h7E);
    else add_random($urandom_range(0, 12), 8'h21, 8'h7E);
    add_text(" HTTP/1.1");
    add_eol();
    repeat ($urandom_range(0, 4)) add_header();
    if ($urandom_range(0, 9) != 0) begin
      add_text("\r\n");
      add_random($urandom_range(0, 24), 8'h00, 8'hFF);
    end
  endfunction

  // Noise, weighted towards the bytes that the parser reacts to.
  function automatic void build_noise();
    msg.delete();
    repeat ($urandom_range(1, 30)) begin
      case ($urandom_range(0, 7))
        0:       msg.push_back(CH_CR);
        1:       msg.push_back(CH_LF);
        2:       msg.push_back(CH_SP);
        3:       msg.push_back(CH_COLON);
        default: msg.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  initial begin
    int sent;
    bit held;
    sb           = new();
    hold_request = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A zero byte and an all-ones byte, the second marked last,
    // so that a summary comes out for a request with no headers.
    msg = '{8'h00, 8'hFF};
    send_message();
    // CR LF CR LF inside the request line still ends the headers.
    msg.delete();
    add_text("\r\n\r\nZ");
    send_message();
    // An ordinary request with a body, leading spaces and a signed length.
    msg.delete();
    add_text("GET  /index.html HTTP/1.1\r\nHost: a\r\nConnection:  close\r\n");
    add_text("Content-Length: +3\r\n\r\nabcd");
    send_message();
    // Bare LF line ends, a line without a colon, a CR inside a name, the last
    // Connection header winning, and a negative length read past a tab.
    msg.delete();
    add_text("PUT / x\nNoColon\nBad\rName: close\nConnection: close\nConnection: keep\n");
    add_text("Content-Length:\t-7x\n\r\n\r\nq");
    send_message();
    // Saturation both ways and no blank line, so the headers never complete.
    msg.delete();
    add_text("HEAD / \r\nContent-Length: 99999999999\r\nConnection: close\r\n");
    add_text("Content-Length: -2147483649\r\nX:");
    send_message();
    // The blank line arrives while the path is still being read.
    msg.delete();
    add_text("POST /\r\n\r\n");
    send_message();

    // Every text field past its limit: method, path, header name and header
    // value, followed by a short body.
    msg.delete();
    add_random(17, "A", "Z");
    add_text(" /");
    add_random(257, "a", "z");
    add_text(" HTTP/1.1\r\n");
    add_random(257, "A", "Z");
    add_text(": close\r\nConnection: ");
    add_random(257, "a", "z");
    add_text("\r\nContent-Length: 5000\r\n\r\n");
    add_random(16, 8'h00, 8'hFF);
    send_message();
    pause_until_drained();

    // Random part: mostly well-formed requests, the rest noise. Part way in,
    // the receiver is asked for its long hold-off.
    sent = 0;
    held = 1'b0;
    while (sent < RANDOM_BYTES) begin
      if (!held && sent >= 80) begin
        hold_request = 1'b1;
        held         = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) build_request();
      else build_noise();
      sent += msg.size();
      send_message();
    end

    // Drain, then leave a few cycles for any stray transaction to show up.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
